### hdl/tlik_pkg.sv
package tlik_pkg;

	localparam int POS_WIDTH    = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int LEN_WIDTH    = 15;
	localparam int DIFF_WIDTH   = POS_WIDTH + 1;
	localparam int SUM_WIDTH    = POS_WIDTH + 6;
	localparam int CW           = 50;
	localparam int ZW           = 34;
	localparam int RW           = CW - 30;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int MW           = 33;

	localparam logic [29:0] INV_GAIN = 30'd652032874;

	localparam logic [1:0] REG_LINK1 = 2'd0;
	localparam logic [1:0] REG_LINK2 = 2'd1;
	localparam logic [1:0] REG_BASE_X = 2'd2;
	localparam logic [1:0] REG_BASE_Y = 2'd3;

	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_req_t;

	typedef struct packed {
		logic                 done;
		logic [31:0]          ang;
		logic signed [RW-1:0] cx;
		logic signed [RW-1:0] cy;
	} cordic_rsp_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] quant_angle(input logic [31:0] z);
		logic [31:0] r;
		r = z + (32'd1 << (31 - ANGLE_WIDTH));
		return r[31 -: ANGLE_WIDTH];
	endfunction

	function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_WIDTH-1:0] v);
		logic signed [SUM_WIDTH-1:0] hi;
		logic signed [SUM_WIDTH-1:0] lo;
		logic [POS_WIDTH-1:0]        r;
		hi = SUM_WIDTH'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
		lo = -hi - SUM_WIDTH'(1);
		if (v > hi) begin
			r = hi[POS_WIDTH-1:0];
		end else if (v < lo) begin
			r = lo[POS_WIDTH-1:0];
		end else begin
			r = v[POS_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/tlik_cordic.sv
module tlik_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tlik_pkg::cordic_req_t            req,
	input  logic signed [tlik_pkg::CW-1:0]   x_in,
	input  logic signed [tlik_pkg::CW-1:0]   y_in,
	input  logic [31:0]                      z_in,
	output tlik_pkg::cordic_rsp_t            rsp
);
	import tlik_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_NORM = 4'b0010,
		C_ITER = 4'b0100,
		C_DONE = 4'b1000
	} cstate_t;

	cstate_t               state_q;
	logic signed [CW-1:0]  x_q, y_q;
	logic [CW-1:0]         m_q;
	logic signed [ZW-1:0]  z_q;
	logic [STEP_W-1:0]     step_q;
	logic                  rot_q, flip_q;

	logic [CW-1:0]         ax, ay;
	logic [31:0]           zsum, zrot;
	logic signed [CW-1:0]  dx, dy;
	logic signed [ZW-1:0]  atab;
	logic                  ccw;
	logic signed [CW-1:0]  xr_sum, yr_sum;
	logic signed [RW-1:0]  xr, yr;

	always_comb begin
		ax   = x_in[CW-1] ? CW'(-x_in) : CW'(x_in);
		ay   = y_in[CW-1] ? CW'(-y_in) : CW'(y_in);
		zsum = z_in + 32'h40000000;
		zrot = zsum[31] ? z_in - 32'h80000000 : z_in;
		dx   = y_q >>> step_q;
		dy   = x_q >>> step_q;
		atab = $signed({{(ZW-32){1'b0}}, atan_entry(5'(step_q))});
		ccw  = rot_q ? !z_q[ZW-1] : !(y_q > 0);
		xr_sum = x_q + (CW'(1) <<< 29);
		yr_sum = y_q + (CW'(1) <<< 29);
		xr   = xr_sum[CW-1:30];
		yr   = yr_sum[CW-1:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						rot_q  <= req.rotate;
						flip_q <= zsum[31];
						step_q <= '0;
						if (req.rotate) begin
							x_q     <= x_in;
							y_q     <= '0;
							z_q     <= ZW'($signed(zrot));
							state_q <= C_ITER;
						end else if (x_in == '0 && y_in == '0) begin
							z_q     <= '0;
							state_q <= C_DONE;
						end else begin
							x_q     <= x_in;
							y_q     <= y_in;
							m_q     <= (ax > ay) ? ax : ay;
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (|m_q[CW-1:31]) begin
						x_q <= x_q >>> 1;
						y_q <= y_q >>> 1;
						m_q <= m_q >> 1;
					end else if (m_q[CW-1:30] == '0) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
						m_q <= m_q << 1;
					end else begin
						if (x_q[CW-1]) begin
							x_q <= -x_q;
							y_q <= -y_q;
							z_q <= ZW'(34'sh080000000);
						end else begin
							z_q <= '0;
						end
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (ccw) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atab;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atab;
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (state_q == C_DONE);
	assign rsp.ang  = z_q[31:0];
	assign rsp.cx   = flip_q ? -xr : xr;
	assign rsp.cy   = flip_q ? -yr : yr;

endmodule

### hdl/two_link_arm_inverse_kinematics.sv
// Channel    Dir  Handshake          Payload
// s_axis     in   s_tvalid/s_tready  s_tdata: target_x, target_y; s_tuser: elbow_negative
// m_axis     out  m_tvalid/m_tready  m_tdata: angles, elbow, tip; m_tuser: unreachable
// apb        in   psel/penable       link1_length, link2_length, base_x, base_y
// A solved request runs the square root, three CORDIC vectoring passes and two rotation
// passes, each with its multiply; its duration varies with the CORDIC normalize shifts.
// An unreachable request skips the solve and goes straight to the rotation passes.
// Reset clears the configuration registers and the held angles to zero.
// s_tready is high only while idle; a stalled result waits in the output register.
module two_link_arm_inverse_kinematics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // target_x[15:0], target_y[31:16]
	input  logic [0:0]  s_tuser,   // elbow_negative[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // shoulder, elbow, elbow_x, elbow_y, tip_x, tip_y
	output logic [0:0]  m_tuser,   // unreachable[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tlik_pkg::*;

	typedef enum logic [25:0] {
		S_IDLE    = 26'd1 << 0,
		S_SQ_PX   = 26'd1 << 1,
		S_SQ_PY   = 26'd1 << 2,
		S_SQ_A1   = 26'd1 << 3,
		S_SQ_A2   = 26'd1 << 4,
		S_MUL_D   = 26'd1 << 5,
		S_CHK     = 26'd1 << 6,
		S_MUL_S   = 26'd1 << 7,
		S_SQRT_LD = 26'd1 << 8,
		S_SQRT    = 26'd1 << 9,
		S_MUL_T1  = 26'd1 << 10,
		S_MUL_T2  = 26'd1 << 11,
		S_MUL_T3  = 26'd1 << 12,
		S_VQ2     = 26'd1 << 13,
		S_VQ2_W   = 26'd1 << 14,
		S_VT2     = 26'd1 << 15,
		S_VT2_W   = 26'd1 << 16,
		S_VQ1     = 26'd1 << 17,
		S_VQ1_W   = 26'd1 << 18,
		S_MUL_R1  = 26'd1 << 19,
		S_ROT1    = 26'd1 << 20,
		S_ROT1_W  = 26'd1 << 21,
		S_MUL_R2  = 26'd1 << 22,
		S_ROT2    = 26'd1 << 23,
		S_ROT2_W  = 26'd1 << 24,
		S_FIN     = 26'd1 << 25
	} state_t;

	state_t                        state_q;
	logic [LEN_WIDTH-1:0]          link1_q, link2_q;
	logic signed [POS_WIDTH-1:0]   base_x_q, base_y_q;
	logic signed [DIFF_WIDTH-1:0]  px_q, py_q;
	logic                          neg_q, unreach_q;
	logic signed [34:0]            acc_q, n_q;
	logic [31:0]                   d_q;
	logic signed [2*MW-1:0]        prod_q;
	logic [63:0]                   sq_v_q;
	logic [33:0]                   sq_rem_q;
	logic [31:0]                   sq_root_q;
	logic [4:0]                    sq_cnt_q;
	logic signed [CW-1:0]          t2x_q, t2y_q;
	logic [31:0]                   q2z_q, t2z_q;
	logic [ANGLE_WIDTH-1:0]        held_sh_q, held_el_q;
	logic signed [RW-1:0]          ex_q, ey_q, rx_q, ry_q;
	logic                          m_tvalid_q;
	logic [95:0]                   m_tdata_q;
	logic                          m_tuser_q;

	logic signed [MW-1:0]          mul_a, mul_b, a1_s, a2_s, sy;
	logic signed [34:0]            dd, dmn, dpn;
	logic [31:0]                   d_chk;
	logic                          ok_chk;
	logic [35:0]                   rem_sh, trial;
	logic                          cfg_wr;
	cordic_req_t                   creq;
	cordic_rsp_t                   crsp;
	logic signed [CW-1:0]          c_x, c_y;
	logic [31:0]                   c_z;
	logic [ANGLE_WIDTH-1:0]        sum_ang;
	logic signed [SUM_WIDTH-1:0]   elx, ely, tpx, tpy;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_LINK1:  prdata = 32'(link1_q);
			REG_LINK2:  prdata = 32'(link2_q);
			REG_BASE_X: prdata = 32'(base_x_q);
			REG_BASE_Y: prdata = 32'(base_y_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		a1_s   = $signed({{(MW-LEN_WIDTH){1'b0}}, link1_q});
		a2_s   = $signed({{(MW-LEN_WIDTH){1'b0}}, link2_q});
		dd     = $signed({3'b000, d_q});
		dmn    = dd - n_q;
		dpn    = dd + n_q;
		sy     = neg_q ? -$signed({1'b0, sq_root_q}) : $signed({1'b0, sq_root_q});
		d_chk  = {prod_q[30:0], 1'b0};
		ok_chk = (link1_q != '0) && (link2_q != '0)
			&& (px_q != {1'b1, {(DIFF_WIDTH-1){1'b0}}})
			&& (py_q != {1'b1, {(DIFF_WIDTH-1){1'b0}}})
			&& !(acc_q > $signed({3'b000, d_chk}))
			&& !(acc_q < -$signed({3'b000, d_chk}));
		rem_sh = {sq_rem_q, sq_v_q[63:62]};
		trial  = {2'b00, sq_root_q, 2'b01};
		sum_ang = held_sh_q + held_el_q;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ_PX:  begin mul_a = MW'(px_q); mul_b = MW'(px_q); end
			S_SQ_PY:  begin mul_a = MW'(py_q); mul_b = MW'(py_q); end
			S_SQ_A1:  begin mul_a = a1_s; mul_b = a1_s; end
			S_SQ_A2:  begin mul_a = a2_s; mul_b = a2_s; end
			S_MUL_D:  begin mul_a = a1_s; mul_b = a2_s; end
			S_MUL_S:  begin mul_a = MW'(dmn); mul_b = MW'(dpn); end
			S_MUL_T1: begin mul_a = a1_s; mul_b = $signed({1'b0, d_q}); end
			S_MUL_T2: begin mul_a = a2_s; mul_b = MW'(n_q); end
			S_MUL_T3: begin mul_a = a2_s; mul_b = sy; end
			S_MUL_R1: begin mul_a = a1_s; mul_b = $signed({3'b000, INV_GAIN}); end
			S_MUL_R2: begin mul_a = a2_s; mul_b = $signed({3'b000, INV_GAIN}); end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		creq = '0;
		c_x  = '0;
		c_y  = '0;
		c_z  = '0;
		case (state_q)
			S_VQ2: begin
				creq.start = 1'b1;
				c_x = CW'(n_q);
				c_y = $signed({{(CW-32){1'b0}}, sq_root_q});
			end
			S_VT2: begin
				creq.start = 1'b1;
				c_x = t2x_q;
				c_y = t2y_q;
			end
			S_VQ1: begin
				creq.start = 1'b1;
				c_x = CW'(px_q);
				c_y = CW'(py_q);
			end
			S_ROT1: begin
				creq.start  = 1'b1;
				creq.rotate = 1'b1;
				c_x = prod_q[CW-1:0];
				c_z = {held_sh_q, {(32-ANGLE_WIDTH){1'b0}}};
			end
			S_ROT2: begin
				creq.start  = 1'b1;
				creq.rotate = 1'b1;
				c_x = prod_q[CW-1:0];
				c_z = {sum_ang, {(32-ANGLE_WIDTH){1'b0}}};
			end
			default: begin
				creq = '0;
			end
		endcase
	end

	tlik_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.x_in   (c_x),
		.y_in   (c_y),
		.z_in   (c_z),
		.rsp    (crsp)
	);

	always_comb begin
		elx = SUM_WIDTH'(base_x_q) + SUM_WIDTH'(ex_q);
		ely = SUM_WIDTH'(base_y_q) + SUM_WIDTH'(ey_q);
		tpx = elx + SUM_WIDTH'(rx_q);
		tpy = ely + SUM_WIDTH'(ry_q);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q  <= '0;
			link2_q  <= '0;
			base_x_q <= '0;
			base_y_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LINK1:  link1_q  <= pwdata[LEN_WIDTH-1:0];
				REG_LINK2:  link2_q  <= pwdata[LEN_WIDTH-1:0];
				REG_BASE_X: base_x_q <= pwdata[POS_WIDTH-1:0];
				REG_BASE_Y: base_y_q <= pwdata[POS_WIDTH-1:0];
				default:    link1_q  <= link1_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			held_sh_q  <= '0;
			held_el_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						px_q    <= DIFF_WIDTH'($signed(s_tdata[15:0])) - DIFF_WIDTH'(base_x_q);
						py_q    <= DIFF_WIDTH'($signed(s_tdata[31:16])) - DIFF_WIDTH'(base_y_q);
						neg_q   <= s_tuser[0];
						state_q <= S_SQ_PX;
					end
				end
				S_SQ_PX: state_q <= S_SQ_PY;
				S_SQ_PY: begin
					acc_q   <= prod_q[34:0];
					state_q <= S_SQ_A1;
				end
				S_SQ_A1: begin
					acc_q   <= acc_q + prod_q[34:0];
					state_q <= S_SQ_A2;
				end
				S_SQ_A2: begin
					acc_q   <= acc_q - prod_q[34:0];
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					acc_q   <= acc_q - prod_q[34:0];
					state_q <= S_CHK;
				end
				S_CHK: begin
					n_q       <= acc_q;
					d_q       <= d_chk;
					unreach_q <= !ok_chk;
					state_q   <= ok_chk ? S_MUL_S : S_MUL_R1;
				end
				S_MUL_S: state_q <= S_SQRT_LD;
				S_SQRT_LD: begin
					sq_v_q    <= prod_q[63:0];
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					sq_cnt_q  <= '0;
					state_q   <= S_SQRT;
				end
				S_SQRT: begin
					if (rem_sh >= trial) begin
						sq_rem_q  <= 34'(rem_sh - trial);
						sq_root_q <= {sq_root_q[30:0], 1'b1};
					end else begin
						sq_rem_q  <= rem_sh[33:0];
						sq_root_q <= {sq_root_q[30:0], 1'b0};
					end
					sq_v_q   <= sq_v_q << 2;
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd31) begin
						state_q <= S_MUL_T1;
					end
				end
				S_MUL_T1: state_q <= S_MUL_T2;
				S_MUL_T2: begin
					t2x_q   <= prod_q[CW-1:0];
					state_q <= S_MUL_T3;
				end
				S_MUL_T3: begin
					t2x_q   <= t2x_q + prod_q[CW-1:0];
					state_q <= S_VQ2;
				end
				S_VQ2: begin
					t2y_q   <= prod_q[CW-1:0];
					state_q <= S_VQ2_W;
				end
				S_VQ2_W: begin
					if (crsp.done) begin
						q2z_q   <= neg_q ? 32'd0 - crsp.ang : crsp.ang;
						state_q <= S_VT2;
					end
				end
				S_VT2: state_q <= S_VT2_W;
				S_VT2_W: begin
					if (crsp.done) begin
						t2z_q   <= crsp.ang;
						state_q <= S_VQ1;
					end
				end
				S_VQ1: state_q <= S_VQ1_W;
				S_VQ1_W: begin
					if (crsp.done) begin
						held_sh_q <= quant_angle(crsp.ang - t2z_q);
						held_el_q <= quant_angle(q2z_q);
						state_q   <= S_MUL_R1;
					end
				end
				S_MUL_R1: state_q <= S_ROT1;
				S_ROT1:   state_q <= S_ROT1_W;
				S_ROT1_W: begin
					if (crsp.done) begin
						ex_q    <= crsp.cx;
						ey_q    <= crsp.cy;
						state_q <= S_MUL_R2;
					end
				end
				S_MUL_R2: state_q <= S_ROT2;
				S_ROT2:   state_q <= S_ROT2_W;
				S_ROT2_W: begin
					if (crsp.done) begin
						rx_q    <= crsp.cx;
						ry_q    <= crsp.cy;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {sat_pos(tpy), sat_pos(tpx), sat_pos(ely),
							sat_pos(elx), held_el_q, held_sh_q};
						m_tuser_q  <= unreach_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted request did not drop s_tready");

	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> (state_q == S_VQ2_W || state_q == S_VT2_W || state_q == S_VQ1_W
			|| state_q == S_ROT1_W || state_q == S_ROT2_W))
		else $error("CORDIC result with no sequencer waiting");

	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && (!m_tvalid || m_tready) |=> m_tvalid && s_tready)
		else $error("finished request not moved to output register");
`endif

endmodule

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlik_pkg::*;

	typedef struct {
		logic [15:0] shoulder;
		logic [15:0] elbow;
		logic [15:0] elbow_x;
		logic [15:0] elbow_y;
		logic [15:0] tip_x;
		logic [15:0] tip_y;
		logic        unreachable;
	} arm_pose_t;

	class arm_pose_board;
		arm_pose_t   pending[$];
		int          errors;
		longint      len1, len2, shoulder_x, shoulder_y;
		int unsigned kept_q1, kept_q2;
		int unsigned arc[0:15] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

		function void set_reg(int idx, logic [31:0] v);
			case (idx)
				REG_LINK1: len1 = longint'(v[14:0]);
				REG_LINK2: len2 = longint'(v[14:0]);
				REG_BASE_X: shoulder_x = longint'($signed(v[15:0]));
				REG_BASE_Y: shoulder_y = longint'($signed(v[15:0]));
				default: ;
			endcase
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function int unsigned heading(longint y, longint x);
			int unsigned z;
			longint m, dx, dy;
			z = 0;
			if (x == 0 && y == 0) return 0;
			m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
			while (m >= (64'sd1 <<< 31)) begin
				x = x >>> 1;
				y = y >>> 1;
				m = m >>> 1;
			end
			while (m < (64'sd1 <<< 30)) begin
				x = x * 2;
				y = y * 2;
				m = m * 2;
			end
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h80000000;
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x = x + dx;
					y = y - dy;
					z = z + arc[i];
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - arc[i];
				end
			end
			return z;
		endfunction

		function void swing(longint len, int unsigned ang, output longint ox, output longint oy);
			bit     flip;
			longint x, y, z, dx, dy;
			int unsigned t;
			flip = 0;
			x = len * 64'sd652032874;
			y = 0;
			t = ang + 32'h40000000;
			if (t >= 32'h80000000) begin
				flip = 1;
				ang = ang - 32'h80000000;
			end
			z = longint'($signed(ang));
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(arc[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(arc[i]);
				end
			end
			x = (x + (64'sd1 <<< 29)) >>> 30;
			y = (y + (64'sd1 <<< 29)) >>> 30;
			ox = flip ? -x : x;
			oy = flip ? -y : y;
		endfunction

		function int unsigned to_turn16(int unsigned z);
			int unsigned r;
			r = z + 32'h00008000;
			return r >> 16;
		endfunction

		function logic [15:0] clip(longint v);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		function void note_request(logic [15:0] tx, logic [15:0] ty, logic neg);
			longint      px, py, n, d, s, ex, ey, rx, ry, elx, ely;
			bit          ok;
			int unsigned q2z, t2, q1, q12;
			arm_pose_t   e;
			px = longint'($signed(tx)) - shoulder_x;
			py = longint'($signed(ty)) - shoulder_y;
			ok = len1 != 0 && len2 != 0 && px < 65536 && px > -65536 && py < 65536 && py > -65536;
			if (ok) begin
				n = px * px + py * py - len1 * len1 - len2 * len2;
				d = 2 * len1 * len2;
				if (n > d || n < -d) ok = 0;
			end
			if (ok) begin
				s = longint'(root(longint'(unsigned'(d - n)) * longint'(unsigned'(d + n))));
				q2z = heading(s, n);
				if (neg) q2z = 0 - q2z;
				t2 = heading(len2 * (neg ? -s : s), len1 * d + len2 * n);
				kept_q1 = to_turn16(heading(py, px) - t2);
				kept_q2 = to_turn16(q2z);
			end
			q1 = kept_q1 << 16;
			q12 = q1 + (kept_q2 << 16);
			swing(len1, q1, ex, ey);
			swing(len2, q12, rx, ry);
			elx = shoulder_x + ex;
			ely = shoulder_y + ey;
			e.shoulder = kept_q1[15:0];
			e.elbow = kept_q2[15:0];
			e.elbow_x = clip(elx);
			e.elbow_y = clip(ely);
			e.tip_x = clip(elx + rx);
			e.tip_y = clip(ely + ry);
			e.unreachable = !ok;
			pending = {pending, e};
		endfunction

		function void check_result(logic [95:0] data, logic unr);
			arm_pose_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[15:0] !== e.shoulder) begin
				$error("shoulder_angle exp %h got %h", e.shoulder, data[15:0]);
				errors++;
			end
			if (data[31:16] !== e.elbow) begin
				$error("elbow_angle exp %h got %h", e.elbow, data[31:16]);
				errors++;
			end
			if (data[47:32] !== e.elbow_x) begin
				$error("elbow_x exp %h got %h", e.elbow_x, data[47:32]);
				errors++;
			end
			if (data[63:48] !== e.elbow_y) begin
				$error("elbow_y exp %h got %h", e.elbow_y, data[63:48]);
				errors++;
			end
			if (data[79:64] !== e.tip_x) begin
				$error("tip_x exp %h got %h", e.tip_x, data[79:64]);
				errors++;
			end
			if (data[95:80] !== e.tip_y) begin
				$error("tip_y exp %h got %h", e.tip_y, data[95:80]);
				errors++;
			end
			if (unr !== e.unreachable) begin
				$error("unreachable exp %b got %b", e.unreachable, unr);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // target_x[15:0], target_y[31:16]
	logic [0:0]  s_tuser = '0;  // elbow_negative[0]
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [95:0] m_tdata;       // shoulder, elbow, elbow_x, elbow_y, tip_x, tip_y
	logic [0:0]  m_tuser;       // unreachable[0]
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	arm_pose_board board = new();
	bit            calm;

	two_link_arm_inverse_kinematics dut (.*);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= calm || $urandom_range(99) >= 23;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			board.check_result(m_tdata, m_tuser[0]);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		board.set_reg(idx, v);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic send(logic [15:0] tx, logic [15:0] ty, logic neg);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 23) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {ty, tx};
		s_tuser = neg;
		do @(posedge clk); while (!s_tready);
		board.note_request(tx, ty, neg);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic setup(int l1, int l2, int bx, int by);
		write_reg(REG_LINK1, l1);
		write_reg(REG_LINK2, l2);
		write_reg(REG_BASE_X, bx);
		write_reg(REG_BASE_Y, by);
	endtask

	task automatic aim(int count);
		longint reach, tx, ty;
		reach = board.len1 + board.len2;
		if (reach > 65535) reach = 65535;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 75) begin
				tx = board.shoulder_x + longint'($urandom_range(2 * reach)) - reach;
				ty = board.shoulder_y + longint'($urandom_range(2 * reach)) - reach;
				if (tx > 32767) tx = 32767;
				if (tx < -32768) tx = -32768;
				if (ty > 32767) ty = 32767;
				if (ty < -32768) ty = -32768;
			end else begin
				tx = $urandom_range(16'hFFFF);
				ty = $urandom_range(16'hFFFF);
			end
			send(tx[15:0], ty[15:0], $urandom_range(1));
		end
	endtask

	initial begin
		calm = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send(16'd2800, 16'd0, 0);
		send(16'h7FFF, 16'h8000, 1);
		drain();
		setup(1600, 1200, 0, 0);
		send(16'd2800, 16'd0, 0);
		send(16'd400, 16'd0, 1);
		send(16'd0, 16'd0, 0);
		send(16'd0, 16'd2000, 0);
		send(16'd0, 16'd2000, 1);
		send(-16'sd2000, 16'd1000, 0);
		send(-16'sd2000, -16'sd1000, 1);
		send(16'h7FFF, 16'h7FFF, 0);
		send(16'h8000, 16'h8000, 1);
		send(16'h0000, -16'sd2800, 0);
		send(-16'sd2800, 16'h0000, 1);
		calm = 1;
		aim(100);
		calm = 0;
		aim(160);
		drain();
		setup(32767, 32767, 32'hFFFF8000, 32'h00007FFF);
		send(16'h7FFF, 16'h8000, 0);
		send(16'h8000, 16'h7FFF, 1);
		send(16'h8000, 16'h8000, 0);
		aim(200);
		drain();
		setup(1, 1, 0, 0);
		send(16'd2, 16'd0, 0);
		send(16'd0, 16'd0, 1);
		send(16'd1, 16'd1, 0);
		aim(150);
		drain();
		setup(4000, 1, 32'h00001234, 32'hFFFFEDCC);
		aim(200);
		drain();
		setup(20000, 9000, 32'hFFFFC000, 32'h00002000);
		aim(250);
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("tb failed");
		$finish;
	end

endmodule

### two_link_arm_inverse_kinematics.f
hdl/tlik_pkg.sv
hdl/tlik_cordic.sv
hdl/two_link_arm_inverse_kinematics.sv
dv/tb.sv
